// ===== rtl/rc4_pkg.sv =====
`timescale 1ns / 1ps

package rc4_pkg;

    // Sizes of the largest configuration the core supports.
    localparam int MAX_WORD_BITS = 8;
    localparam int MAX_KEY_WORDS = 256;
    localparam int WORD_W        = MAX_WORD_BITS;
    localparam int TABLE_DEPTH   = 1 << MAX_WORD_BITS;
    localparam int KEY_AW        = $clog2(MAX_KEY_WORDS);
    localparam int WBITS_W       = 4;
    localparam int KLEN_W        = 9;
    localparam int MODE_W        = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 9;
    localparam int OP_W          = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_BITS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [WBITS_W-1:0] WORD_BITS_RST  = 4'd8;
    localparam logic [KLEN_W-1:0]  KEY_LENGTH_RST = 9'd16;

    // Request modes carried by an input word.
    localparam logic [MODE_W-1:0] MODE_KEY_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SCHEDULE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GENERATE = 2'd2;

    // Datapath operations issued by the controller, one per cycle.
    typedef logic [OP_W-1:0] t_dp_op;
    localparam t_dp_op OP_IDLE    = 4'd0;
    localparam t_dp_op OP_KS_INIT = 4'd1;
    localparam t_dp_op OP_KS_RD   = 4'd2;
    localparam t_dp_op OP_KS_J    = 4'd3;
    localparam t_dp_op OP_KS_WI   = 4'd4;
    localparam t_dp_op OP_KS_WJ   = 4'd5;
    localparam t_dp_op OP_GEN_J   = 4'd6;
    localparam t_dp_op OP_GEN_T   = 4'd7;
    localparam t_dp_op OP_GEN_K   = 4'd8;
    localparam t_dp_op OP_HOLD    = 4'd9;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_AW-1:0] key_index;
        logic [WORD_W-1:0] key_word;
        logic [WORD_W-1:0] data_word;
    } t_in_word;

    typedef struct packed {
        t_dp_op op;
        logic   accept;
    } t_dp_cmd;

    typedef struct packed {
        logic ks_last;
        logic out_free;
    } t_dp_status;

    // Word width clamped to the supported range.
    function automatic logic [WBITS_W-1:0] eff_word_bits(input logic [WBITS_W-1:0] wb);
        logic [WBITS_W-1:0] r;
        if (wb == '0) begin
            r = WBITS_W'(1);
        end else if (wb > WBITS_W'(MAX_WORD_BITS)) begin
            r = WBITS_W'(MAX_WORD_BITS);
        end else begin
            r = wb;
        end
        return r;
    endfunction

    // Mask with the low word-width bits set.
    function automatic logic [WORD_W-1:0] word_mask(input logic [WBITS_W-1:0] wb);
        logic [WBITS_W-1:0] eb;
        eb = eff_word_bits(wb);
        return {WORD_W{1'b1}} >> (WBITS_W'(WORD_W) - eb);
    endfunction

    // Key length clamped to the supported range.
    function automatic logic [KLEN_W-1:0] eff_key_len(input logic [KLEN_W-1:0] kl);
        logic [KLEN_W-1:0] r;
        if (kl == '0) begin
            r = KLEN_W'(1);
        end else if (kl > KLEN_W'(MAX_KEY_WORDS)) begin
            r = KLEN_W'(MAX_KEY_WORDS);
        end else begin
            r = kl;
        end
        return r;
    endfunction

endpackage

// ===== rtl/rc4_in_if.sv =====
`timescale 1ns / 1ps

interface rc4_in_if;
    import rc4_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [KEY_AW-1:0] key_index;
    logic [WORD_W-1:0] key_word;
    logic [WORD_W-1:0] data_word;

    modport source (output valid, mode, key_index, key_word, data_word, input ready);
    modport sink   (input valid, mode, key_index, key_word, data_word, output ready);
endinterface

// ===== rtl/rc4_out_if.sv =====
`timescale 1ns / 1ps

interface rc4_out_if;
    import rc4_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] keystream_word;
    logic [WORD_W-1:0] data_out;

    modport source (output valid, keystream_word, data_out, input ready);
    modport sink   (input valid, keystream_word, data_out, output ready);
endinterface

// ===== rtl/rc4_stream_cipher_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Words carried
// i_in_ch   in         mode, key_index, key_word, data_word
// o_out_ch  out        keystream_word, data_out (generate requests only)
// cfg       in         i_cfg_we / i_cfg_idx / i_cfg_data, write only
//
// A key load or an unused mode leaves the controller idle; a generate is paced
// by the three dependent reads and the two writes on the one table port.
// A key schedule first writes each entry once to set the identity, then
// takes each entry through read, read, write, write.
// Reset is synchronous and clears the controller, the generator pointers and
// the output slot; the table and key store hold whatever was last written.
// A result waiting in the output register does not stop new requests; a
// generate finishing behind it waits until that word is taken.

module rc4_stream_cipher_core
    import rc4_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rc4_in_if.sink                i_in_ch,
    rc4_out_if.source             o_out_ch
);

    t_in_word   w_in_word;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    assign w_in_word.mode      = i_in_ch.mode;
    assign w_in_word.key_index = i_in_ch.key_index;
    assign w_in_word.key_word  = i_in_ch.key_word;
    assign w_in_word.data_word = i_in_ch.data_word;
    assign i_in_ch.ready       = w_in_ready;

    // Sequencer.
    rc4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_in_mode  (i_in_ch.mode),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // Tables, pointers and output slot.
    rc4_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_word  (w_in_word),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_ch   (o_out_ch)
    );

endmodule

// ===== rtl/rc4_ram.sv =====
`timescale 1ns / 1ps

module rc4_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // One write port and one registered read port; a read of the address
    // being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rc4_datapath.sv =====
`timescale 1ns / 1ps

module rc4_datapath
    import rc4_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_word              i_in_word,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    rc4_out_if.source             o_out_ch
);

    logic [WBITS_W-1:0] r_word_bits;
    logic [KLEN_W-1:0]  r_key_length;
    logic [WORD_W-1:0]  w_mask;
    logic [KLEN_W-1:0]  w_klen;

    t_in_word           r_in;
    logic [WORD_W-1:0]  r_gen_i;
    logic [WORD_W-1:0]  r_gen_j;
    logic [WORD_W-1:0]  r_c;
    logic [KEY_AW-1:0]  r_ki;
    logic [WORD_W-1:0]  r_i;
    logic [WORD_W-1:0]  r_j;
    logic [WORD_W-1:0]  r_t;
    logic [WORD_W-1:0]  r_si;
    logic [WORD_W-1:0]  r_sj;
    logic [WORD_W-1:0]  r_k;
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_ks;
    logic [WORD_W-1:0]  r_out_data;

    logic               perm_we;
    logic [WORD_W-1:0]  perm_waddr;
    logic [WORD_W-1:0]  perm_wdata;
    logic [WORD_W-1:0]  perm_raddr;
    logic [WORD_W-1:0]  perm_rdata;
    logic               key_we;
    logic [WORD_W-1:0]  key_rdata;

    logic [WORD_W-1:0]  w_next_i;
    logic [WORD_W-1:0]  w_ks_j;
    logic [WORD_W-1:0]  w_gen_j;
    logic [WORD_W-1:0]  w_t;
    logic [WORD_W-1:0]  w_k_raw;
    logic [WORD_W-1:0]  w_k;
    logic               w_ks_last;
    logic               w_ki_wrap;
    logic               w_out_free;
    logic               w_out_load;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_bits  <= WORD_BITS_RST;
            r_key_length <= KEY_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WORD_BITS:  r_word_bits  <= i_cfg_data[WBITS_W-1:0];
                CFG_KEY_LENGTH: r_key_length <= i_cfg_data[KLEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_mask = word_mask(r_word_bits);
    assign w_klen = eff_key_len(r_key_length);

    // Permutation table and key store.
    rc4_ram #(.DATA_W(WORD_W), .DEPTH(TABLE_DEPTH)) u_perm_ram (
        .i_clk   (i_clk),
        .i_we    (perm_we),
        .i_waddr (perm_waddr),
        .i_wdata (perm_wdata),
        .i_raddr (perm_raddr),
        .o_rdata (perm_rdata)
    );

    rc4_ram #(.DATA_W(WORD_W), .DEPTH(MAX_KEY_WORDS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (i_in_word.key_index),
        .i_wdata (i_in_word.key_word & w_mask),
        .i_raddr (r_ki),
        .o_rdata (key_rdata)
    );

    assign key_we = i_cmd.accept && (i_in_word.mode == MODE_KEY_LOAD);

    // Pointer arithmetic, all wrapping at the current word width.
    assign w_next_i = (r_gen_i + WORD_W'(1)) & w_mask;
    assign w_ks_j   = (r_j + (perm_rdata & w_mask) + (key_rdata & w_mask)) & w_mask;
    assign w_gen_j  = (r_gen_j + (perm_rdata & w_mask)) & w_mask;
    assign w_t      = ((r_si & w_mask) + (perm_rdata & w_mask)) & w_mask;

    // The keystream read is issued while entry i is written and before entry j
    // is written, so hits on either swapped entry are forwarded.
    always_comb begin
        if (r_t == r_j) begin
            w_k_raw = r_si;
        end else if (r_t == r_i) begin
            w_k_raw = r_sj;
        end else begin
            w_k_raw = perm_rdata;
        end
    end
    assign w_k = w_k_raw & w_mask;

    assign w_ks_last  = (r_c == w_mask);
    assign w_ki_wrap  = ({1'b0, r_ki} == (w_klen - KLEN_W'(1)));
    assign w_out_free = !r_out_valid || o_out_ch.ready;
    assign w_out_load = w_out_free
                        && ((i_cmd.op == OP_GEN_K) || (i_cmd.op == OP_HOLD));

    // Table port control for each operation.
    always_comb begin
        perm_we    = 1'b0;
        perm_waddr = r_c;
        perm_wdata = r_c;
        perm_raddr = w_next_i;
        unique case (i_cmd.op)
            OP_IDLE: begin
                perm_raddr = w_next_i;
            end
            OP_KS_INIT: begin
                perm_we    = 1'b1;
                perm_waddr = r_c;
                perm_wdata = r_c;
            end
            OP_KS_RD: begin
                perm_raddr = r_c;
            end
            OP_KS_J: begin
                perm_raddr = w_ks_j;
            end
            OP_KS_WI: begin
                perm_we    = 1'b1;
                perm_waddr = r_c;
                perm_wdata = perm_rdata;
            end
            OP_KS_WJ: begin
                perm_we    = 1'b1;
                perm_waddr = r_j;
                perm_wdata = r_si;
            end
            OP_GEN_J: begin
                perm_raddr = w_gen_j;
            end
            OP_GEN_T: begin
                perm_we    = 1'b1;
                perm_waddr = r_i;
                perm_wdata = perm_rdata;
                perm_raddr = w_t;
            end
            OP_GEN_K: begin
                perm_we    = 1'b1;
                perm_waddr = r_j;
                perm_wdata = r_si;
            end
            default: ;
        endcase
    end

    // Working registers of the key schedule and the generator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_i <= '0;
            r_gen_j <= '0;
        end else begin
            if (i_cmd.op == OP_KS_WJ && w_ks_last) begin
                r_gen_i <= '0;
                r_gen_j <= '0;
            end else if (i_cmd.op == OP_GEN_K) begin
                r_gen_i <= r_i;
                r_gen_j <= r_j;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_in_word;
            r_c  <= '0;
            r_ki <= '0;
            r_j  <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_KS_INIT: begin
                    r_c <= (r_c + WORD_W'(1)) & w_mask;
                end
                OP_KS_J: begin
                    r_j  <= w_ks_j;
                    r_si <= perm_rdata;
                end
                OP_KS_WJ: begin
                    r_c  <= (r_c + WORD_W'(1)) & w_mask;
                    r_ki <= w_ki_wrap ? '0 : r_ki + KEY_AW'(1);
                end
                OP_GEN_J: begin
                    r_i  <= w_next_i;
                    r_j  <= w_gen_j;
                    r_si <= perm_rdata;
                end
                OP_GEN_T: begin
                    r_sj <= perm_rdata;
                    r_t  <= w_t;
                end
                OP_GEN_K: begin
                    r_k <= w_k;
                end
                default: ;
            endcase
        end
    end

    // Output register: loaded when the slot is free, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (i_cmd.op == OP_GEN_K) begin
                r_out_ks   <= w_k;
                r_out_data <= (r_in.data_word & w_mask) ^ w_k;
            end else begin
                r_out_ks   <= r_k;
                r_out_data <= (r_in.data_word & w_mask) ^ r_k;
            end
        end
    end

    assign o_out_ch.valid          = r_out_valid;
    assign o_out_ch.keystream_word = r_out_ks;
    assign o_out_ch.data_out       = r_out_data;

    assign o_status.ks_last  = w_ks_last;
    assign o_status.out_free = w_out_free;

endmodule

// ===== rtl/rc4_ctrl.sv =====
`timescale 1ns / 1ps

module rc4_ctrl
    import rc4_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [MODE_W-1:0] i_in_mode,
    input  t_dp_status        i_status,
    output logic              o_in_ready,
    output t_dp_cmd           o_cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_KS_INIT = 4'd1;
    localparam logic [3:0] ST_KS_RD   = 4'd2;
    localparam logic [3:0] ST_KS_J    = 4'd3;
    localparam logic [3:0] ST_KS_WI   = 4'd4;
    localparam logic [3:0] ST_KS_WJ   = 4'd5;
    localparam logic [3:0] ST_GEN_J   = 4'd6;
    localparam logic [3:0] ST_GEN_T   = 4'd7;
    localparam logic [3:0] ST_GEN_K   = 4'd8;
    localparam logic [3:0] ST_HOLD    = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_mode)
                        MODE_SCHEDULE: n_state = ST_KS_INIT;
                        MODE_GENERATE: n_state = ST_GEN_J;
                        default:       n_state = ST_IDLE;
                    endcase
                end
            end
            ST_KS_INIT: n_state = i_status.ks_last ? ST_KS_RD : ST_KS_INIT;
            ST_KS_RD:   n_state = ST_KS_J;
            ST_KS_J:    n_state = ST_KS_WI;
            ST_KS_WI:   n_state = ST_KS_WJ;
            ST_KS_WJ:   n_state = i_status.ks_last ? ST_IDLE : ST_KS_RD;
            ST_GEN_J:   n_state = ST_GEN_T;
            ST_GEN_T:   n_state = ST_GEN_K;
            ST_GEN_K:   n_state = i_status.out_free ? ST_IDLE : ST_HOLD;
            ST_HOLD:    n_state = i_status.out_free ? ST_IDLE : ST_HOLD;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Operation issued to the datapath in each state.
    always_comb begin
        o_cmd.accept = w_accept;
        unique case (r_state)
            ST_KS_INIT: o_cmd.op = OP_KS_INIT;
            ST_KS_RD:   o_cmd.op = OP_KS_RD;
            ST_KS_J:    o_cmd.op = OP_KS_J;
            ST_KS_WI:   o_cmd.op = OP_KS_WI;
            ST_KS_WJ:   o_cmd.op = OP_KS_WJ;
            ST_GEN_J:   o_cmd.op = OP_GEN_J;
            ST_GEN_T:   o_cmd.op = OP_GEN_T;
            ST_GEN_K:   o_cmd.op = OP_GEN_K;
            ST_HOLD:    o_cmd.op = OP_HOLD;
            default:    o_cmd.op = OP_IDLE;
        endcase
    end

endmodule

// ===== rtl/rc4_checker.sv =====
`timescale 1ns / 1ps

module rc4_checker
    import rc4_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [MODE_W-1:0] i_in_mode,
    input logic              i_out_valid,
    input logic              i_out_ready
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    // A waiting result word stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word withdrawn before it was taken");

    // A generate request keeps the input closed while it runs.
    a_gen_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in_mode == MODE_GENERATE) |=> !i_in_ready)
        else $error("input open during a generate");

    // A key load finishes in its own cycle.
    a_key_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in_mode == MODE_KEY_LOAD) |=> i_in_ready)
        else $error("input closed after a key load");

    // A new result word must trace back to an accepted generate request.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(w_in_acc && (i_in_mode == MODE_GENERATE), 4))
        else $error("result word without a matching generate");

endmodule

bind rc4_stream_cipher_core rc4_checker u_rc4_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_in_mode   (i_in_ch.mode),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready)
);
